@@ rtl/core/ascii_integer_parser_defines.svh @@
// ---------------------------------------------------------------------------
// ascii integer parser assertion macros
// concurrent assertion forms used by the parser queue rtl
// ---------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// expression holds at every edge out of reset
`define AIP_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent is checked at the clock edge that follows the antecedent
`define AIP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/aip_pkg.sv @@
// ---------------------------------------------------------------------------
// aip_pkg
// types and constants shared by the ascii integer parser modules
// ---------------------------------------------------------------------------
package aip_pkg;

  localparam int VALUE_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [3:0] HEX_LETTER_OFS = 4'h9;

  typedef enum logic [2:0] {
    TK_SPACE,
    TK_PLUS,
    TK_MINUS,
    TK_ZERO,
    TK_DEC,
    TK_X,
    TK_HEXL,
    TK_OTHER
  } tok_class_t;

  typedef struct packed {
    logic       first;
    tok_class_t cls;
    logic [3:0] digit;
  } token_t;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_ZERO,
    PH_HEX,
    PH_DEC
  } phase_t;

endpackage

@@ rtl/core/ascii_integer_parser.sv @@
// ---------------------------------------------------------------------------
// ascii_integer_parser
// parses one decimal or hex integer per string from a character stream
// ---------------------------------------------------------------------------
//  channel   signals                          direction
//  input     in_valid in_ready ch first       in
//  output    out_valid out_ready value        out
//  config    cfg_wr_en cfg_wr_data            in
//
//  one character per cycle while the token queue has room; a result
//  is registered in the cycle after the parser takes its terminating character
//  a four-entry token queue lets input run on while the result stalls
//  rst is synchronous and clears parser state; signed_mode resets to 1
// ---------------------------------------------------------------------------
module ascii_integer_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    ch,
  input  logic                          first,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aip_pkg::OUT_BITS-1:0]  value
);
  import aip_pkg::*;

  logic   signed_mode;
  logic   f_valid;
  logic   f_ready;
  token_t f_tok;
  logic   b_valid;
  logic   b_ready;
  token_t b_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      signed_mode <= cfg_wr_data;
    end
  end

  aip_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .first       (first),
    .signed_mode (signed_mode),
    .tok_valid   (f_valid),
    .tok_ready   (f_ready),
    .tok         (f_tok)
  );

  aip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_tok    (b_tok)
  );

  aip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (b_valid),
    .tok_ready (b_ready),
    .tok       (b_tok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
  );

endmodule

@@ rtl/core/aip_front.sv @@
// ---------------------------------------------------------------------------
// aip_front
// accepts characters and classifies them into parser tokens
// ---------------------------------------------------------------------------
module aip_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      ch,
  input  logic            first,
  input  logic            signed_mode,
  output logic            tok_valid,
  input  logic            tok_ready,
  output aip_pkg::token_t tok
);
  import aip_pkg::*;

  assign tok_valid = in_valid;
  assign in_ready  = tok_ready;

  always_comb begin
    tok.first = first;
    tok.digit = ch[3:0];
    if (ch == CH_SPACE) begin
      tok.cls = TK_SPACE;
    end else if (signed_mode && ch == CH_PLUS) begin
      tok.cls = TK_PLUS;
    end else if (signed_mode && ch == CH_MINUS) begin
      tok.cls = TK_MINUS;
    end else if (ch == CH_ZERO) begin
      tok.cls = TK_ZERO;
    end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
      tok.cls = TK_DEC;
    end else if (ch == CH_LX || ch == CH_UX) begin
      tok.cls = TK_X;
    end else if (ch inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
      tok.cls   = TK_HEXL;
      tok.digit = ch[3:0] + HEX_LETTER_OFS;
    end else begin
      tok.cls = TK_OTHER;
    end
  end

endmodule

@@ rtl/core/aip_queue.sv @@
// ---------------------------------------------------------------------------
// aip_queue
// short token queue between the classifier and the parser
// ---------------------------------------------------------------------------
`include "ascii_integer_parser_defines.svh"

module aip_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  aip_pkg::token_t push_tok,
  output logic            pop_valid,
  input  logic            pop_ready,
  output aip_pkg::token_t pop_tok
);
  import aip_pkg::*;

  token_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 push;
  logic                 pop;

  assign push_ready = count != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_tok    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AIP_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
  `AIP_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "count up")
  `AIP_ASSERT_NEXT(a_count_dn, clk, rst, pop && !push, count == $past(count) - 1'b1, "count down")

endmodule

@@ rtl/core/aip_back.sv @@
// ---------------------------------------------------------------------------
// aip_back
// parser state machine, accumulator and result register
// ---------------------------------------------------------------------------
module aip_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tok_valid,
  output logic                          tok_ready,
  input  aip_pkg::token_t               tok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aip_pkg::OUT_BITS-1:0]  value
);
  import aip_pkg::*;

  phase_t                phase;
  phase_t                phase_next;
  logic                  negative;
  logic                  negative_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic [VALUE_BITS-1:0] acc_in;
  logic [VALUE_BITS-1:0] result;
  logic [VALUE_BITS-1:0] digit_ext;
  logic                  emit;
  logic                  take;

  assign tok_ready = !out_valid || out_ready;
  assign take      = tok_valid && tok_ready;
  assign acc_in    = tok.first ? '0 : acc;
  assign digit_ext = VALUE_BITS'(tok.digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_DONE;
      negative <= 1'b0;
      acc      <= '0;
    end else if (take) begin
      phase    <= phase_next;
      negative <= negative_next;
      acc      <= acc_next;
    end
  end

  always_comb begin
    phase_next    = tok.first ? PH_LEAD : phase;
    negative_next = tok.first ? 1'b0 : negative;
    acc_next      = acc_in;
    emit          = 1'b0;
    case (phase_next)
      PH_LEAD: begin
        case (tok.cls)
          TK_SPACE, TK_PLUS: begin
          end
          TK_MINUS: begin
            negative_next = !negative_next;
          end
          TK_ZERO: begin
            phase_next = PH_ZERO;
          end
          TK_DEC: begin
            acc_next   = digit_ext;
            phase_next = PH_DEC;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      PH_ZERO: begin
        if (tok.cls == TK_X) begin
          acc_next   = '0;
          phase_next = PH_HEX;
        end else if (tok.cls inside {TK_ZERO, TK_DEC}) begin
          acc_next   = digit_ext;
          phase_next = PH_DEC;
        end else begin
          acc_next = '0;
          emit     = 1'b1;
        end
      end
      PH_HEX: begin
        if (tok.cls inside {TK_ZERO, TK_DEC, TK_HEXL}) begin
          acc_next = {acc_in[VALUE_BITS-5:0], tok.digit};
        end else begin
          emit = 1'b1;
        end
      end
      PH_DEC: begin
        if (tok.cls inside {TK_ZERO, TK_DEC}) begin
          acc_next = (acc_in << 3) + (acc_in << 1) + digit_ext;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  assign result = negative_next ? (~acc_next + 1'b1) : acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      value <= OUT_BITS'(result);
    end
  end

endmodule
